// ===== design/hmd_pkg.sv =====
package hmd_pkg;

    localparam int FRAME_LEN   = 31;
    localparam int BYTE_W      = 8;
    localparam int DATA_BITS   = 26;
    localparam int COUNT_WIDTH = 32;
    localparam int CORR_W      = 32;
    localparam int GROUP_DEPTH = 4;
    localparam int GROUP_PTR_W = $clog2(GROUP_DEPTH);
    localparam int SYN_W       = 5;
    localparam int FILL_W      = 5;
    localparam int PACK_W      = 7;
    localparam int PFILL_W     = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              restart;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [CORR_W-1:0] corrected_frames;
        logic              last;
    } t_out_item;

    // one decoded frame: three or four bytes, first byte in the top lane
    typedef struct packed {
        logic [4*BYTE_W-1:0] bytes;
        logic                four;
        logic [CORR_W-1:0]   corrected;
    } t_group;

    typedef struct packed {
        logic   push;
        t_group group;
    } t_group_wr;

    // XOR of the positions of all set bits; position p lives in bit FRAME_LEN-p
    function automatic logic [SYN_W-1:0] syndrome(input logic [FRAME_LEN-1:0] f);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= FRAME_LEN; p++) begin
            if (f[FRAME_LEN-p]) begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

    // drop parity positions, first data bit lands in the MSB
    function automatic logic [DATA_BITS-1:0] data_bits(input logic [FRAME_LEN-1:0] f);
        logic [DATA_BITS-1:0] d;
        d = '0;
        for (int p = 1; p <= FRAME_LEN; p++) begin
            if ((p & (p - 1)) != 0) begin
                d = {d[DATA_BITS-2:0], f[FRAME_LEN-p]};
            end
        end
        return d;
    endfunction

endpackage

// ===== design/hamming_31_26_stream_decoder.sv =====
// Hamming (31,26) stream decoder.
// Input channel (i_valid / o_ready / i_item): one encoded byte per item, bits
// taken MSB first into a 31-bit frame; restart clears frame alignment, the
// byte packer and the correction count before that byte is used.
// Output channel (o_valid / i_ready / o_item): decoded data bytes, first data
// bit in the MSB, with the saturating count of corrected frames; last marks
// the final byte caused by one input item. A byte that completes no frame
// gives no item; one that completes a frame gives three or four.
// An accepted item is held in an input register and decoded from it; a
// completed frame is written to the buffer, whose head byte is then offered.
// Throughput: one input item per cycle; one output byte per cycle, drained
// from a four-frame buffer. Input stalls only when that buffer is full and
// the held item completes a frame.
// A stalled receiver holds the current byte steady; the buffer then fills
// and back-pressure reaches the input.
// Reset (sync, active low) empties the buffer, clears all control state.
module hamming_31_26_stream_decoder
    import hmd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_group_wr wr;
    logic      full;

    hmd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_wr    (wr)
    );

    hmd_group_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

// ===== design/hmd_decode.sv =====
module hmd_decode
    import hmd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  logic      i_full,
    output t_group_wr o_wr
);

    localparam logic [FILL_W-1:0]  FILL_DONE = FILL_W'(FRAME_LEN - BYTE_W);
    localparam logic [PFILL_W-1:0] PF_FOUR   = PFILL_W'(4*BYTE_W - DATA_BITS);

    logic                   r_in_valid;
    t_in_item               r_in;
    logic [FRAME_LEN-1:0]   r_frame, n_frame;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [PACK_W-1:0]      r_pack, n_pack;
    logic [PFILL_W-1:0]     r_pfill, n_pfill;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic [FRAME_LEN-1:0]        base_frame, full_frame, fixed_frame;
    logic [FILL_W-1:0]           base_fill;
    logic [PACK_W-1:0]           base_pack;
    logic [PFILL_W-1:0]          base_pfill;
    logic [COUNT_WIDTH-1:0]      base_count;
    logic                        complete, fire, four;
    logic [3:0]                  take;
    logic [SYN_W-1:0]            syn;
    logic [DATA_BITS-1:0]        dbits;
    logic [PACK_W+DATA_BITS-1:0] packed_w, aligned;

    always_comb begin
        base_frame = r_in.restart ? '0 : r_frame;
        base_fill  = r_in.restart ? '0 : r_fill;
        base_pack  = r_in.restart ? '0 : r_pack;
        base_pfill = r_in.restart ? '0 : r_pfill;
        base_count = r_in.restart ? '0 : r_count;

        complete = base_fill >= FILL_DONE;
        take     = 4'(FRAME_LEN) - 4'(base_fill);

        full_frame  = (base_frame << take)
                    | FRAME_LEN'(r_in.code_byte >> (4'(BYTE_W) - take));
        syn         = syndrome(full_frame);
        fixed_frame = full_frame;
        if (syn != '0) begin
            fixed_frame[SYN_W'(FRAME_LEN) - syn] = ~full_frame[SYN_W'(FRAME_LEN) - syn];
        end
        dbits    = data_bits(fixed_frame);
        packed_w = {base_pack, dbits};
        aligned  = packed_w << (PFILL_W'(PACK_W) - base_pfill);
        four     = base_pfill >= PF_FOUR;

        n_frame = {base_frame[FRAME_LEN-BYTE_W-1:0], r_in.code_byte};
        n_fill  = base_fill + FILL_W'(BYTE_W);
        n_pack  = base_pack;
        n_pfill = base_pfill;
        n_count = base_count;
        if (complete) begin
            n_frame = FRAME_LEN'(r_in.code_byte);
            n_fill  = FILL_W'(4'(BYTE_W) - take);
            n_pack  = packed_w[PACK_W-1:0];
            n_pfill = four ? base_pfill - PF_FOUR : base_pfill + PFILL_W'(2);
            if (syn != '0 && base_count != '1) begin
                n_count = base_count + 1'b1;
            end
        end

        fire    = r_in_valid && (!complete || !i_full);
        o_ready = !r_in_valid || fire;

        o_wr.push            = fire && complete;
        o_wr.group.bytes     = aligned[PACK_W+DATA_BITS-1 -: 4*BYTE_W];
        o_wr.group.four      = four;
        o_wr.group.corrected = CORR_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_frame    <= '0;
            r_fill     <= '0;
            r_pack     <= '0;
            r_pfill    <= '0;
            r_count    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_frame <= n_frame;
                r_fill  <= n_fill;
                r_pack  <= n_pack;
                r_pfill <= n_pfill;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

endmodule

// ===== design/hmd_group_fifo.sv =====
module hmd_group_fifo
    import hmd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group_wr i_wr,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_group                 r_mem [GROUP_DEPTH];
    logic [GROUP_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [GROUP_PTR_W:0]   r_level;
    logic [1:0]             r_idx;
    t_group                 head;
    logic                   last, pop;

    always_comb begin
        head    = r_mem[r_rd_ptr];
        o_full  = r_level == (GROUP_PTR_W+1)'(GROUP_DEPTH);
        o_valid = r_level != '0;
        last    = head.four ? (r_idx == 2'd3) : (r_idx == 2'd2);
        pop     = o_valid && i_ready && last;

        unique case (r_idx)
            2'd0:    o_item.data_byte = head.bytes[4*BYTE_W-1 -: BYTE_W];
            2'd1:    o_item.data_byte = head.bytes[3*BYTE_W-1 -: BYTE_W];
            2'd2:    o_item.data_byte = head.bytes[2*BYTE_W-1 -: BYTE_W];
            default: o_item.data_byte = head.bytes[BYTE_W-1 -: BYTE_W];
        endcase
        o_item.corrected_frames = head.corrected;
        o_item.last             = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (o_valid && i_ready) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= r_level + (GROUP_PTR_W+1)'(i_wr.push) - (GROUP_PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.group;
        end
    end

endmodule
